FILE: rtl/core/bpi_pkg.sv
// Package for the bicycle pose integrator: widths, codes, CORDIC constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpi_pkg;
	localparam int POS_WIDTH_DEF    = 32;
	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// request types
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_PRESS   = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// key codes
	localparam logic [2:0] KEY_FWD   = 3'd0;
	localparam logic [2:0] KEY_BACK  = 3'd1;
	localparam logic [2:0] KEY_LEFT  = 3'd2;
	localparam logic [2:0] KEY_RIGHT = 3'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_SPEED  = 2'd0;
	localparam logic [1:0] CFG_MAX_STEER  = 2'd1;
	localparam logic [1:0] CFG_WHEEL_BASE = 2'd2;

	// direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd2;

	localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic [31:0]        RAD_TO_TURN = 32'd683565276;
	localparam logic [63:0]        TAN_CAP     = 64'h3FFF_FFFF;

	// arctangent table in 2^32 units per turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/bicycle_pose_integrator.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | req_type, key_code
// out     | out | out_valid/out_ready| pos_x, pos_y, heading
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// Press, release and unused items go straight to the update. A tick runs a heading
// CORDIC, when turning a steering CORDIC and a 64-bit bit-serial divide for the tangent
// and another for the turn ratio, then the product, cap and update states.
// One item is in work at a time; a result waiting in the output register
// stalls acceptance. arst_n clears state and pose; no clearing pass.
// Depends on bpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bicycle_pose_integrator #(
	parameter int POS_WIDTH    = bpi_pkg::POS_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = bpi_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = bpi_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             req_type,
	input  wire logic [2:0]             key_code,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [31:0]          pos_x,
	output logic signed [31:0]          pos_y,
	output logic [15:0]                 heading,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [15:0]            cfg_data
);
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [SW:0] LAST_STEP = (SW + 1)'(CORDIC_STEPS - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_H_CORD, ST_DXY, ST_S_CORD, ST_TAN_DIV, ST_RAT_MUL,
		ST_RAT_DIV, ST_DELTA, ST_UPDATE, ST_OUT
	} state_t;

	state_t state_q;
	logic [15:0] max_speed_q, wheel_base_q;
	logic [13:0] max_steer_q;
	logic [1:0]  drive_dir_q, steer_dir_q;
	logic signed [POS_WIDTH-1:0] x_pos_q, y_pos_q;
	logic [ANGLE_WIDTH-1:0] head_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic flip_q;
	logic [SW:0] step_q;
	logic signed [55:0] dx_q, dy_q;
	logic [63:0] num_q, rem_q, quo_q, den_q;
	logic [5:0]  bit_q;
	logic [63:0] d_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [15:0] heading_q;

	// one CORDIC rotation step
	logic signed [35:0] sh_x, sh_y, nx, ny;
	logic signed [33:0] nz;
	logic [31:0] atn;
	always_comb begin
		sh_x = cx_q >>> step_q;
		sh_y = cy_q >>> step_q;
		atn  = bpi_pkg::atan_turn(5'(step_q));
		if (!cz_q[33]) begin
			nx = cx_q - sh_y; ny = cy_q + sh_x; nz = cz_q - $signed({2'b0, atn});
		end else begin
			nx = cx_q + sh_y; ny = cy_q - sh_x; nz = cz_q + $signed({2'b0, atn});
		end
	end

	// cordic seeding from a binary angle
	function automatic logic [32:0] seed(input logic [ANGLE_WIDTH-1:0] a);
		logic [31:0] t;
		logic f;
		t = {a, {(32-ANGLE_WIDTH){1'b0}}};
		f = t[31] ^ t[30];
		if (f) t = t + 32'h8000_0000;
		return {f, t};
	endfunction

	// shift-subtract divide step
	logic [64:0] trial;
	logic [63:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[62:0], num_q[63]};
		trial  = {1'b0, rem_sh} - {1'b0, den_q};
	end

	logic signed [17:0] v_s;
	logic [ANGLE_WIDTH-1:0] quarter, m_st;
	logic [32:0] sd_h, sd_s;
	logic signed [POS_WIDTH+1:0] sx, sy;
	logic signed [POS_WIDTH+1:0] lim_hi, lim_lo;
	logic [95:0] dprod;
	always_comb begin
		case (drive_dir_q)
			bpi_pkg::DIR_POS: v_s = $signed({2'b0, max_speed_q});
			bpi_pkg::DIR_NEG: v_s = -$signed({2'b0, max_speed_q});
			default:          v_s = '0;
		endcase
		quarter = {2'b00, {(ANGLE_WIDTH-2){1'b1}}};
		m_st = ANGLE_WIDTH'(max_steer_q);
		if ({18'b0, max_steer_q} > 32'(quarter)) m_st = quarter;
		sd_h = seed(head_q);
		sd_s = seed(m_st);
		sx = (POS_WIDTH+2)'(x_pos_q) + (POS_WIDTH+2)'(dx_q >>> 22);
		sy = (POS_WIDTH+2)'(y_pos_q) + (POS_WIDTH+2)'(dy_q >>> 22);
		lim_hi = (POS_WIDTH+2)'({1'b0, {(POS_WIDTH-1){1'b1}}});
		lim_lo = -lim_hi - 1;
		dprod = {32'b0, d_q} * 96'(bpi_pkg::RAD_TO_TURN);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign heading = heading_q;

	// sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_speed_q <= 16'd256; max_steer_q <= 14'd5461; wheel_base_q <= 16'd512;
			drive_dir_q <= bpi_pkg::DIR_NONE; steer_dir_q <= bpi_pkg::DIR_NONE;
			x_pos_q <= '0; y_pos_q <= '0; head_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bpi_pkg::CFG_MAX_SPEED:  max_speed_q  <= cfg_data;
					bpi_pkg::CFG_MAX_STEER:  max_steer_q  <= cfg_data[13:0];
					bpi_pkg::CFG_WHEEL_BASE: wheel_base_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_UPDATE;
					if (req_type == bpi_pkg::REQ_TICK) begin
						flip_q <= sd_h[32];
						cx_q <= bpi_pkg::CORDIC_GAIN; cy_q <= '0;
						cz_q <= $signed({{2{sd_h[31]}}, sd_h[31:0]});
						step_q <= '0;
						state_q <= ST_H_CORD;
					end else if (req_type == bpi_pkg::REQ_PRESS) begin
						case (key_code)
							bpi_pkg::KEY_FWD:   drive_dir_q <= bpi_pkg::DIR_POS;
							bpi_pkg::KEY_BACK:  drive_dir_q <= bpi_pkg::DIR_NEG;
							bpi_pkg::KEY_LEFT:  steer_dir_q <= bpi_pkg::DIR_POS;
							bpi_pkg::KEY_RIGHT: steer_dir_q <= bpi_pkg::DIR_NEG;
							default: ;
						endcase
					end else if (req_type == bpi_pkg::REQ_RELEASE) begin
						case (key_code)
							bpi_pkg::KEY_FWD, bpi_pkg::KEY_BACK:
								drive_dir_q <= bpi_pkg::DIR_NONE;
							bpi_pkg::KEY_LEFT, bpi_pkg::KEY_RIGHT:
								steer_dir_q <= bpi_pkg::DIR_NONE;
							default: ;
						endcase
					end
					dx_q <= '0; dy_q <= '0; d_q <= '0;
				end
				ST_H_CORD: begin
					cx_q <= nx; cy_q <= ny; cz_q <= nz; step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= ST_DXY;
				end
				ST_DXY: begin
					// position deltas, rounded half up
					dx_q <= 56'(v_s) * 56'(flip_q ? -cx_q : cx_q) + 56'sd2097152;
					dy_q <= 56'(v_s) * 56'(flip_q ? -cy_q : cy_q) + 56'sd2097152;
					state_q <= ST_UPDATE;
					if (drive_dir_q != bpi_pkg::DIR_NONE && steer_dir_q != bpi_pkg::DIR_NONE
						&& max_speed_q != 16'd0 && m_st != '0) begin
						flip_q <= sd_s[32];
						cx_q <= bpi_pkg::CORDIC_GAIN; cy_q <= '0;
						cz_q <= $signed({{2{sd_s[31]}}, sd_s[31:0]});
						step_q <= '0;
						state_q <= ST_S_CORD;
					end
				end
				ST_S_CORD: begin
					cx_q <= nx; cy_q <= ny; cz_q <= nz; step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_TAN_DIV;
						// sine floored at zero, cosine at one
						num_q <= ((flip_q ? -ny : ny) < 0) ? 64'd0
							: {12'b0, 36'(flip_q ? -ny : ny), 16'b0};
						den_q <= ((flip_q ? -nx : nx) < 36'sd1) ? 64'd1
							: {28'b0, 36'(flip_q ? -nx : nx)};
						rem_q <= '0; quo_q <= '0; bit_q <= '0;
					end
				end
				ST_TAN_DIV, ST_RAT_DIV: begin
					num_q <= {num_q[62:0], 1'b0};
					if (!trial[64]) begin
						rem_q <= trial[63:0]; quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh; quo_q <= {quo_q[62:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'd63) state_q <= (state_q == ST_TAN_DIV) ? ST_RAT_MUL
						: ST_DELTA;
				end
				ST_RAT_MUL: begin
					num_q <= 64'(max_speed_q) * ((quo_q > bpi_pkg::TAN_CAP)
						? bpi_pkg::TAN_CAP : quo_q);
					den_q <= (wheel_base_q == 16'd0) ? 64'd1 : 64'(wheel_base_q);
					rem_q <= '0; quo_q <= '0; bit_q <= '0;
					state_q <= ST_RAT_DIV;
				end
				ST_DELTA: begin
					d_q <= (quo_q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo_q;
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					logic [ANGLE_WIDTH-1:0] dd;
					dd = ANGLE_WIDTH'((dprod + (96'd1 << (47 - ANGLE_WIDTH)))
						>> (48 - ANGLE_WIDTH));
					if ((drive_dir_q == bpi_pkg::DIR_NEG) != (steer_dir_q == bpi_pkg::DIR_NEG))
						head_q <= head_q - dd;
					else
						head_q <= head_q + dd;
					x_pos_q <= (sx > lim_hi) ? POS_WIDTH'(lim_hi)
						: (sx < lim_lo) ? POS_WIDTH'(lim_lo) : POS_WIDTH'(sx);
					y_pos_q <= (sy > lim_hi) ? POS_WIDTH'(lim_hi)
						: (sy < lim_lo) ? POS_WIDTH'(lim_lo) : POS_WIDTH'(sy);
					pos_x_q <= 32'((sx > lim_hi) ? lim_hi : (sx < lim_lo) ? lim_lo : sx);
					pos_y_q <= 32'((sy > lim_hi) ? lim_hi : (sy < lim_lo) ? lim_lo : sy);
					heading_q <= 16'(((drive_dir_q == bpi_pkg::DIR_NEG)
						!= (steer_dir_q == bpi_pkg::DIR_NEG)) ? head_q - dd : head_q + dd);
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// at most one of the two sides is open
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("in_ready and out_valid together");
	// an accepted beat is followed by busy
	assert property (@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> !in_ready)
		else $error("accepted while busy");
	// a held result keeps its x position and heading
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(heading)))
		else $error("result changed while stalled");
endmodule
`default_nettype wire
